[hdl/vmap_pkg.sv]
`default_nettype none

package vmap_pkg;

  localparam int STORE_ADDR_BITS_DEF = 16;

  typedef logic [2:0] func_t;
  typedef logic [1:0] cfg_idx_t;

  localparam func_t FUNC_ADDR_LO = 3'd0;
  localparam func_t FUNC_ADDR_HI = 3'd1;
  localparam func_t FUNC_DATA_LO = 3'd2;
  localparam func_t FUNC_DATA_HI = 3'd3;
  localparam func_t FUNC_READ_LO = 3'd4;
  localparam func_t FUNC_READ_HI = 3'd5;

  localparam cfg_idx_t CFG_INC_HIGH  = 2'd0;
  localparam cfg_idx_t CFG_REMAP     = 2'd1;
  localparam cfg_idx_t CFG_STEP_SEL  = 2'd2;
  localparam cfg_idx_t CFG_FBLANK    = 2'd3;

  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_8    = 2'd1;
  localparam logic [1:0] REMAP_9    = 2'd2;
  localparam logic [1:0] REMAP_10   = 2'd3;

  localparam logic [1:0] STEP_SEL_1  = 2'd0;
  localparam logic [1:0] STEP_SEL_32 = 2'd1;

  function automatic logic [15:0] remap_addr(input logic [15:0] a, input logic [1:0] mode);
    logic [15:0] r;
    case (mode)
      REMAP_8:  r = {a[15:8], a[4:0], a[7:5]};
      REMAP_9:  r = {a[15:9], a[5:0], a[8:6]};
      REMAP_10: r = {a[15:10], a[6:0], a[9:7]};
      default:  r = a;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] step_amount(input logic [1:0] sel);
    logic [15:0] s;
    case (sel)
      STEP_SEL_1:  s = 16'd1;
      STEP_SEL_32: s = 16'd32;
      default:     s = 16'd128;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/vmap_ram.sv]
`default_nettype none

module vmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/video_memory_access_port.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_func, in_data, in_in_vblank
// out_      output     out_valid / out_stall  out_read_data
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// An address write or a read that refetches passes through ST_FETCH: the store read is
// registered and loads the prefetch buffer there. Any other transaction skips ST_FETCH.
// After reset the store is cleared one word a cycle, all 2**(STORE_ADDR_BITS-1) words,
// with in_stall high; configuration writes are taken during that pass.
// While out_stall holds a result in the output register, one more transaction is
// accepted and completes, and its result waits until the output register frees.

`default_nettype none

module video_memory_access_port #(
  parameter int STORE_ADDR_BITS = vmap_pkg::STORE_ADDR_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vmap_pkg::func_t     in_func,
  input  wire logic [7:0]          in_data,
  input  wire logic                in_in_vblank,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_read_data,
  input  wire logic                cfg_we,
  input  wire vmap_pkg::cfg_idx_t  cfg_index,
  input  wire logic [1:0]          cfg_data
);

  import vmap_pkg::*;

  localparam int WORD_BITS = STORE_ADDR_BITS - 1;
  localparam int DEPTH = 1 << WORD_BITS;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_FETCH, ST_DONE} state_t;

  state_t state_r;
  logic [WORD_BITS-1:0] clr_r;
  logic [15:0] wa_r;
  logic [15:0] buf_r;
  logic [7:0] res_r;
  logic acc_r;
  logic out_valid_r;
  logic [7:0] out_read_data_r;

  logic inc_high_r;
  logic [1:0] remap_r;
  logic [1:0] step_sel_r;
  logic fblank_r;

  logic [15:0] wa_nxt;
  logic [15:0] addr_acc;
  logic [15:0] remapped;
  logic [WORD_BITS-1:0] idx;
  logic refetch;
  logic wr_lo;
  logic wr_hi;
  logic [7:0] res_nxt;
  logic acc;
  logic take;
  logic clearing;
  logic out_free;
  logic out_load;
  logic ram_we_lo;
  logic ram_we_hi;
  logic [WORD_BITS-1:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic [7:0] q_lo;
  logic [7:0] q_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_high_r <= 1'b0;
      remap_r    <= REMAP_NONE;
      step_sel_r <= STEP_SEL_1;
      fblank_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INC_HIGH: inc_high_r <= cfg_data[0];
        CFG_REMAP:    remap_r <= cfg_data;
        CFG_STEP_SEL: step_sel_r <= cfg_data;
        CFG_FBLANK:   fblank_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign acc = fblank_r | in_in_vblank;
  assign take = in_valid && (state_r == ST_IDLE);
  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((take && !refetch) || (state_r == ST_FETCH) ||
                                 (state_r == ST_DONE));

  always_comb begin
    wa_nxt = wa_r;
    addr_acc = wa_r;
    refetch = 1'b0;
    wr_lo = 1'b0;
    wr_hi = 1'b0;
    res_nxt = 8'd0;
    case (in_func)
      FUNC_ADDR_LO: begin
        wa_nxt = {wa_r[15:8], in_data};
        addr_acc = wa_nxt;
        refetch = 1'b1;
      end
      FUNC_ADDR_HI: begin
        wa_nxt = {in_data, wa_r[7:0]};
        addr_acc = wa_nxt;
        refetch = 1'b1;
      end
      FUNC_DATA_LO: begin
        wr_lo = acc;
        if (!inc_high_r) begin
          wa_nxt = wa_r + step_amount(step_sel_r);
        end
      end
      FUNC_DATA_HI: begin
        wr_hi = acc;
        if (inc_high_r) begin
          wa_nxt = wa_r + step_amount(step_sel_r);
        end
      end
      FUNC_READ_LO: begin
        res_nxt = buf_r[7:0];
        if (!inc_high_r) begin
          refetch = 1'b1;
          wa_nxt = wa_r + step_amount(step_sel_r);
        end
      end
      FUNC_READ_HI: begin
        res_nxt = buf_r[15:8];
        if (inc_high_r) begin
          refetch = 1'b1;
          wa_nxt = wa_r + step_amount(step_sel_r);
        end
      end
      default: ;
    endcase
  end

  assign remapped = remap_addr(addr_acc, remap_r);
  assign idx = remapped[WORD_BITS-1:0];

  assign ram_we_lo = clearing || (take && wr_lo);
  assign ram_we_hi = clearing || (take && wr_hi);
  assign ram_waddr = clearing ? clr_r : idx;
  assign ram_wdata = clearing ? 8'd0 : in_data;

  vmap_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (ram_we_lo),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (q_lo)
  );

  vmap_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (ram_we_hi),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (q_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      wa_r <= 16'd0;
      buf_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + WORD_BITS'(1);
          if (clr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            wa_r <= wa_nxt;
            res_r <= res_nxt;
            acc_r <= acc;
            if (refetch) begin
              state_r <= ST_FETCH;
            end else if (out_free) begin
              out_read_data_r <= res_nxt;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_FETCH: begin
          buf_r <= acc_r ? {q_hi, q_lo} : 16'd0;
          if (out_free) begin
            out_read_data_r <= res_r;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_read_data_r <= res_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_read_data = out_read_data_r;

  a_fetch_after_refetch: assert property (@(posedge clk) disable iff (!rst_n)
    take && refetch |=> state_r == ST_FETCH)
    else $error("refetch transaction did not enter the fetch cycle");

  a_blocked_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH && !acc_r |=> buf_r == 16'd0)
    else $error("blocked refetch loaded nonzero buffer");

  a_done_waits_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> out_valid_r)
    else $error("result held while output register is empty");

  a_clear_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r && !take)
    else $error("activity during store clear");

endmodule

`default_nettype wire
